FILE: sv/r2y_pkg.sv
// Shared constants, types and register codes for the RGB to YUV 4:2:0 converter.
package r2y_pkg;

   localparam int MaxDimension = 4096;
   localparam int CountWidth   = $clog2(MaxDimension);
   localparam int DimWidth     = 13;
   localparam int CsrIndexWidth = 2;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SOURCE_WIDTH     = 2'd0,
      CSR_SOURCE_HEIGHT    = 2'd1,
      CSR_INPUT_HAS_ALPHA  = 2'd2,
      CSR_OUTPUT_HAS_ALPHA = 2'd3
   } csr_index_type;

   localparam logic [DimWidth-1:0] ResetWidth  = DimWidth'(640);
   localparam logic [DimWidth-1:0] ResetHeight = DimWidth'(480);
   localparam logic [DimWidth-1:0] MaxDimValue = DimWidth'(MaxDimension);

   typedef struct packed {
      logic [DimWidth-1:0] source_width;
      logic [DimWidth-1:0] source_height;
      logic                input_has_alpha;
      logic                output_has_alpha;
   } cfg_type;

   // Position flags for the pixel of the current beat
   typedef struct packed {
      logic keep;
      logic chroma;
      logic last;
   } pos_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } yuv_type;

endpackage

FILE: sv/r2y_pos_tracker.sv
// Column and row counters that classify each source pixel beat.
module r2y_pos_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  r2y_pkg::cfg_type            cfg,
   input  logic                        advance,
   output r2y_pkg::pos_type            pos
);
   import r2y_pkg::*;

   logic [CountWidth-1:0] col_ff, col_in;
   logic [CountWidth-1:0] row_ff, row_in;
   logic [DimWidth-1:0]   width_c, height_c;
   logic [DimWidth-1:0]   width_al, height_al;
   logic [DimWidth-1:0]   col_ext, row_ext;
   logic [DimWidth-1:0]   col_inc, row_inc;

   // Clamp dimensions to [1, MaxDimension], then align down to four
   always_comb begin
      if (cfg.source_width == '0) begin
         width_c = DimWidth'(1);
      end else if (cfg.source_width > MaxDimValue) begin
         width_c = MaxDimValue;
      end else begin
         width_c = cfg.source_width;
      end
      if (cfg.source_height == '0) begin
         height_c = DimWidth'(1);
      end else if (cfg.source_height > MaxDimValue) begin
         height_c = MaxDimValue;
      end else begin
         height_c = cfg.source_height;
      end
      width_al  = {width_c[DimWidth-1:2], 2'b00};
      height_al = {height_c[DimWidth-1:2], 2'b00};
   end

   // Classify the current pixel
   always_comb begin
      col_ext    = DimWidth'(col_ff);
      row_ext    = DimWidth'(row_ff);
      pos.keep   = (col_ext < width_al) && (row_ext < height_al);
      pos.chroma = !col_ff[0] && !row_ff[0];
      pos.last   = (col_ext == width_al - DimWidth'(1)) &&
                   (row_ext == height_al - DimWidth'(1));
   end

   // Raster step; an out-of-range column ends its row at once
   always_comb begin
      col_inc = col_ext + DimWidth'(1);
      row_inc = row_ext + DimWidth'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (advance) begin
         if (col_inc >= width_c) begin
            col_in = '0;
            if (row_inc >= height_c) begin
               row_in = '0;
            end else begin
               row_in = row_inc[CountWidth-1:0];
            end
         end else begin
            col_in = col_inc[CountWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: sv/r2y_color_matrix.sv
// BT.601 studio-range color matrix with constant coefficients.
module r2y_color_matrix (
   input  logic [7:0]       red,
   input  logic [7:0]       green,
   input  logic [7:0]       blue,
   input  logic             chroma,
   output r2y_pkg::yuv_type yuv
);
   import r2y_pkg::*;

   logic        [16:0] y_sum;
   logic signed [17:0] r_s, g_s, b_s;
   logic signed [17:0] cb_sum, cr_sum;
   logic signed [17:0] cb_sh, cr_sh;

   always_comb begin
      // Luma sum is always non-negative
      y_sum = 17'd66 * {9'd0, red} + 17'd129 * {9'd0, green} +
              17'd25 * {9'd0, blue} + 17'd128;
      yuv.luma = y_sum[15:8] + 8'd16;

      // Chroma sums are signed; floor via arithmetic shift
      r_s    = signed'({10'd0, red});
      g_s    = signed'({10'd0, green});
      b_s    = signed'({10'd0, blue});
      cb_sum = 18'sd128 - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd112 * b_s;
      cr_sum = 18'sd128 + 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s;
      cb_sh  = cb_sum >>> 8;
      cr_sh  = cr_sum >>> 8;
      if (chroma) begin
         yuv.chroma_blue = cb_sh[7:0] + 8'd128;
         yuv.chroma_red  = cr_sh[7:0] + 8'd128;
      end else begin
         yuv.chroma_blue = '0;
         yuv.chroma_red  = '0;
      end
   end

endmodule

FILE: sv/rgb_to_yuv420_converter.sv
// Top level: RGB(A) pixel stream to BT.601 4:2:0 luma/chroma beats.
// A req beat is taken into the input register at its accepting edge; the result
// register loads from it once it is free or being taken, and the rsp beat is then valid.
// Throughput: one pixel per cycle while rsp_stall is low; the input and result
// registers form a two-stage pipeline; cropped pixels are dropped without a result.
// Reset: counters return to the frame origin, registers to 640x480 RGB, no alpha.
module rgb_to_yuv420_converter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [r2y_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [r2y_pkg::DimWidth-1:0]   csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_red,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_blue,
   input  logic [7:0]                     req_alpha_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_luma,
   output logic [7:0]                     rsp_chroma_blue,
   output logic [7:0]                     rsp_chroma_red,
   output logic                           rsp_chroma_valid,
   output logic [7:0]                     rsp_alpha_out,
   output logic                           rsp_alpha_valid,
   output logic                           rsp_last_of_frame
);
   import r2y_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   pos_type  pos;
   yuv_type  yuv;
   logic     accept, advance;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_red_ff, s1_green_ff, s1_blue_ff, s1_alpha_ff;
   logic       s1_chroma_ff, s1_last_ff, s1_alpha_valid_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:     cfg_in.source_width     = csr_data;
            CSR_SOURCE_HEIGHT:    cfg_in.source_height    = csr_data;
            CSR_INPUT_HAS_ALPHA:  cfg_in.input_has_alpha  = csr_data[0];
            CSR_OUTPUT_HAS_ALPHA: cfg_in.output_has_alpha = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width     <= ResetWidth;
         cfg_ff.source_height    <= ResetHeight;
         cfg_ff.input_has_alpha  <= 1'b0;
         cfg_ff.output_has_alpha <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline handshake: result register frees up or is taken this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   r2y_pos_tracker u_pos (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (accept),
      .pos     (pos)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = pos.keep;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register; alpha is resolved against the config here
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_red_ff         <= req_red;
         s1_green_ff       <= req_green;
         s1_blue_ff        <= req_blue;
         s1_chroma_ff      <= pos.chroma;
         s1_last_ff        <= pos.last;
         s1_alpha_valid_ff <= cfg_ff.output_has_alpha;
         if (!cfg_ff.output_has_alpha) begin
            s1_alpha_ff <= 8'd0;
         end else if (cfg_ff.input_has_alpha) begin
            s1_alpha_ff <= req_alpha_in;
         end else begin
            s1_alpha_ff <= 8'd255;
         end
      end
   end

   r2y_color_matrix u_matrix (
      .red    (s1_red_ff),
      .green  (s1_green_ff),
      .blue   (s1_blue_ff),
      .chroma (s1_chroma_ff),
      .yuv    (yuv)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_luma          <= yuv.luma;
         rsp_chroma_blue   <= yuv.chroma_blue;
         rsp_chroma_red    <= yuv.chroma_red;
         rsp_chroma_valid  <= s1_chroma_ff;
         rsp_alpha_out     <= s1_alpha_ff;
         rsp_alpha_valid   <= s1_alpha_valid_ff;
         rsp_last_of_frame <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma >= 8'd16 && rsp_luma <= 8'd235))
      else $error("luma out of studio range");
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chroma_valid) |-> (rsp_chroma_blue == 8'd0 && rsp_chroma_red == 8'd0))
      else $error("chroma nonzero on a luma-only beat");
   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chroma_valid) |->
         (rsp_chroma_blue >= 8'd16 && rsp_chroma_blue <= 8'd240 &&
          rsp_chroma_red >= 8'd16 && rsp_chroma_red <= 8'd240))
      else $error("chroma out of studio range");
   a_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_alpha_valid) |-> (rsp_alpha_out == 8'd0))
      else $error("alpha nonzero while alpha output is off");
`endif

endmodule
